FILE: rtl/core/tpwvs_pkg.sv
// Shared types and constants for the three-phase window voltage statistics block.
// No dependencies.
package tpwvs_pkg;

  localparam int MAX_WINDOW  = 4096;
  localparam int SAMPLE_BITS = 16;

  localparam int SQ_W   = 42;
  localparam int SUM_W  = 29;
  localparam int CNT_W  = 13;
  localparam int LVL_W  = 15;
  localparam int TIME_W = 32;

  localparam logic [CNT_W-1:0] WIN_RESET  = 13'd1000;
  localparam logic [LVL_W-1:0] TLOW_RESET = 15'd13248;
  localparam logic [LVL_W-1:0] THI_RESET  = 15'd16192;
  localparam logic [LVL_W-1:0] CLIP_RESET = 15'd20794;

  // register indexes
  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_TLOW   = 2'd1;
  localparam logic [1:0] REG_THI    = 2'd2;
  localparam logic [1:0] REG_CLIP   = 2'd3;

  localparam logic RK_CLIP    = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  // one result as it leaves the block
  typedef struct packed {
    logic              kind;
    logic [1:0]        phase;
    logic [2:0]        mask;
    logic [TIME_W-1:0] etime;
    logic [14:0]       rms;
    logic [15:0]       p2p;
    logic [15:0]       dc;
    logic              in_tol;
    logic [CNT_W-1:0]  clips;
    logic              last;
  } result_t;

  // window snapshot handed from front to back for one phase
  typedef struct packed {
    logic [1:0]       phase;
    logic [SQ_W-1:0]  sq;
    logic [SUM_W-1:0] sum;
    logic [15:0]      p2p;
    logic [CNT_W-1:0] clips;
    logic [CNT_W-1:0] n;
  } job_t;

  // front-to-back queue entry: a clip event or a phase summary job
  typedef struct packed {
    logic              kind;
    logic [2:0]        mask;
    logic [TIME_W-1:0] etime;
    logic              last;
    job_t              job;
  } entry_t;

endpackage

FILE: rtl/core/tpwvs_front.sv
// Front end: accumulates per-phase window statistics, issues queue entries.
// Depends on tpwvs_pkg.
module tpwvs_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [tpwvs_pkg::SAMPLE_BITS-1:0] phase_a_sample,
  input  logic signed [tpwvs_pkg::SAMPLE_BITS-1:0] phase_b_sample,
  input  logic signed [tpwvs_pkg::SAMPLE_BITS-1:0] phase_c_sample,
  input  logic [tpwvs_pkg::TIME_W-1:0]         sample_time,
  input  logic [tpwvs_pkg::CNT_W-1:0]          window_length,
  input  logic [tpwvs_pkg::LVL_W-1:0]          clip_level,
  output logic                                 q_push,
  output tpwvs_pkg::entry_t                    q_data,
  input  logic                                 q_full
);
  localparam int SAMPLE_BITS = tpwvs_pkg::SAMPLE_BITS;
  localparam int MAX_WINDOW  = tpwvs_pkg::MAX_WINDOW;
  localparam int SQ_W  = tpwvs_pkg::SQ_W;
  localparam int SUM_W = tpwvs_pkg::SUM_W;
  localparam int CNT_W = tpwvs_pkg::CNT_W;
  localparam int PW    = 2 * SAMPLE_BITS;

  // pending entries of the current item: clip event + up to three summaries
  logic [3:0]          pend;
  tpwvs_pkg::entry_t   pe [4];

  logic [SQ_W-1:0]     sq  [3];
  logic signed [SUM_W-1:0] sm [3];
  logic signed [SAMPLE_BITS-1:0] mx [3];
  logic signed [SAMPLE_BITS-1:0] mn [3];
  logic [CNT_W-1:0]    cc  [3];
  logic [CNT_W-1:0]    seen;

  logic signed [SAMPLE_BITS-1:0] smp [3];
  logic [SQ_W-1:0]     sq_n [3];
  logic signed [SUM_W-1:0] sm_n [3];
  logic signed [SAMPLE_BITS-1:0] mx_n [3];
  logic signed [SAMPLE_BITS-1:0] mn_n [3];
  logic [CNT_W-1:0]    cc_n [3];
  logic [2:0]          mask;
  logic [CNT_W-1:0]    seen_n;
  logic [CNT_W-1:0]    n_eff;
  logic                close;
  logic                accept;
  logic [1:0]          sel;

  assign full   = (pend != 4'd0);
  assign accept = push && !full;

  assign smp[0] = phase_a_sample;
  assign smp[1] = phase_b_sample;
  assign smp[2] = phase_c_sample;

  // effective window length
  always_comb begin
    if (window_length == '0) n_eff = CNT_W'(1);
    else if (32'(window_length) > MAX_WINDOW) n_eff = CNT_W'(MAX_WINDOW);
    else n_eff = window_length;
  end

  // per-phase accumulate
  always_comb begin
    logic signed [PW-1:0] p;
    logic [SQ_W:0] s;
    for (int i = 0; i < 3; i++) begin
      p = smp[i] * smp[i];
      s = {1'b0, sq[i]} + (SQ_W+1)'($unsigned(p));
      sq_n[i] = s[SQ_W] ? {SQ_W{1'b1}} : s[SQ_W-1:0];
      sm_n[i] = sm[i] + SUM_W'(smp[i]);
      mx_n[i] = mx[i];
      mn_n[i] = mn[i];
      if (smp[i] > mx[i]) mx_n[i] = smp[i];
      else if (smp[i] < mn[i]) mn_n[i] = smp[i];
      mask[i] = ($signed({{(33-SAMPLE_BITS){smp[i][SAMPLE_BITS-1]}}, smp[i]}) >=
                 $signed({18'd0, clip_level}));
      cc_n[i] = mask[i] ? cc[i] + CNT_W'(1) : cc[i];
    end
    seen_n = seen + CNT_W'(1);
    close  = (seen_n >= n_eff);
  end

  // pick lowest pending entry
  always_comb begin
    sel = 2'd0;
    if (pend[0]) sel = 2'd0;
    else if (pend[1]) sel = 2'd1;
    else if (pend[2]) sel = 2'd2;
    else sel = 2'd3;
  end

  assign q_push = full && !q_full;
  assign q_data = pe[sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      seen <= '0;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= '0; sm[i] <= '0; mx[i] <= '0; mn[i] <= '0; cc[i] <= '0;
      end
    end else begin
      if (q_push) pend[sel] <= 1'b0;
      if (accept) begin
        pe[0].kind  <= tpwvs_pkg::RK_CLIP;
        pe[0].mask  <= mask;
        pe[0].etime <= sample_time;
        pe[0].last  <= !close;
        pe[0].job   <= '0;
        for (int i = 0; i < 3; i++) begin
          pe[i+1].kind      <= tpwvs_pkg::RK_SUMMARY;
          pe[i+1].mask      <= '0;
          pe[i+1].etime     <= '0;
          pe[i+1].last      <= (i == 2);
          pe[i+1].job.phase <= 2'(i);
          pe[i+1].job.sq    <= sq_n[i];
          pe[i+1].job.sum   <= sm_n[i];
          pe[i+1].job.p2p   <= 16'(32'(mx_n[i]) - 32'(mn_n[i]));
          pe[i+1].job.clips <= cc_n[i];
          pe[i+1].job.n     <= n_eff;
        end
        pend <= {{3{close}}, (mask != 3'd0)};
        if (close) begin
          seen <= '0;
          for (int i = 0; i < 3; i++) begin
            sq[i] <= '0; sm[i] <= '0; mx[i] <= '0; mn[i] <= '0; cc[i] <= '0;
          end
        end else begin
          seen <= seen_n;
          for (int i = 0; i < 3; i++) begin
            sq[i] <= sq_n[i]; sm[i] <= sm_n[i]; mx[i] <= mx_n[i];
            mn[i] <= mn_n[i]; cc[i] <= cc_n[i];
          end
        end
      end
    end
  end
endmodule

FILE: rtl/core/tpwvs_fifo.sv
// Short queue between front and back ends.
// Depends on tpwvs_pkg.
module tpwvs_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  tpwvs_pkg::entry_t wdata,
  output logic              q_full,
  input  logic              rd,
  output tpwvs_pkg::entry_t rdata,
  output logic              q_empty
);
  tpwvs_pkg::entry_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;

  assign q_full  = (cnt == 3'd4);
  assign q_empty = (cnt == 3'd0);
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd) rp <= rp + 2'd1;
      cnt <= cnt + 3'(wr) - 3'(rd);
    end
  end
endmodule

FILE: rtl/core/tpwvs_back.sv
// Back end: divides, takes square roots and forms the outgoing results.
// Depends on tpwvs_pkg.
module tpwvs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  tpwvs_pkg::entry_t             q_data,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic [tpwvs_pkg::LVL_W-1:0]   tolerance_low,
  input  logic [tpwvs_pkg::LVL_W-1:0]   tolerance_high,
  output logic                          empty,
  input  logic                          pop,
  output tpwvs_pkg::result_t            res
);
  localparam int SQ_W  = tpwvs_pkg::SQ_W;
  localparam int SUM_W = tpwvs_pkg::SUM_W;
  localparam int CNT_W = tpwvs_pkg::CNT_W;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT, S_OUT} state_t;
  state_t state;

  logic [5:0]        step;
  logic [SQ_W-1:0]   dq;       // square-sum quotient, then radicand
  logic [CNT_W:0]    drem;     // square-sum remainder
  logic [SUM_W-1:0]  sq2;      // |plain sum| quotient
  logic [CNT_W:0]    srem;
  logic              neg;
  logic [SQ_W-1:0]   rx;       // sqrt remainder
  logic [SQ_W-1:0]   rr;
  logic [SQ_W-1:0]   rbit;
  tpwvs_pkg::entry_t cur;
  logic              have;     // output register loaded

  logic [CNT_W:0] dtry, stry;
  logic [SUM_W-1:0] abs_sum;
  logic [14:0] rms_sat;
  logic [15:0] dc_v;
  logic load_clip, load_sum;

  assign empty = !have;
  assign q_pop = (state == S_IDLE) && !q_empty && (!have || pop);
  assign load_clip = q_pop && (q_data.kind == tpwvs_pkg::RK_CLIP);
  assign load_sum  = (state == S_OUT) && (!have || pop);

  // one restoring divide step each for square sum and plain sum
  always_comb begin
    dtry = {drem[CNT_W-1:0], dq[SQ_W-1]};
    stry = {srem[CNT_W-1:0], sq2[SUM_W-1]};
    abs_sum = q_data.job.sum[SUM_W-1] ? -q_data.job.sum : q_data.job.sum;
    rms_sat = (rr > SQ_W'(32767)) ? 15'd32767 : rr[14:0];
    dc_v    = neg ? -sq2[15:0] : sq2[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      have  <= 1'b0;
    end else begin
      // output register occupancy
      if (load_clip || load_sum) have <= 1'b1;
      else if (pop && have) have <= 1'b0;
      case (state)
        S_IDLE: if (q_pop) begin
          cur <= q_data;
          if (q_data.kind == tpwvs_pkg::RK_CLIP) begin
            res.kind   <= tpwvs_pkg::RK_CLIP;
            res.phase  <= '0;
            res.mask   <= q_data.mask;
            res.etime  <= q_data.etime;
            res.rms    <= '0;
            res.p2p    <= '0;
            res.dc     <= '0;
            res.in_tol <= 1'b0;
            res.clips  <= '0;
            res.last   <= q_data.last;
          end else begin
            dq    <= q_data.job.sq;
            drem  <= '0;
            sq2   <= abs_sum;
            srem  <= '0;
            neg   <= q_data.job.sum[SUM_W-1];
            step  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dtry >= {1'b0, cur.job.n}) begin
            drem <= dtry - {1'b0, cur.job.n};
            dq   <= {dq[SQ_W-2:0], 1'b1};
          end else begin
            drem <= dtry;
            dq   <= {dq[SQ_W-2:0], 1'b0};
          end
          if (step < 6'(SUM_W)) begin
            if (stry >= {1'b0, cur.job.n}) begin
              srem <= stry - {1'b0, cur.job.n};
              sq2  <= {sq2[SUM_W-2:0], 1'b1};
            end else begin
              srem <= stry;
              sq2  <= {sq2[SUM_W-2:0], 1'b0};
            end
          end
          step <= step + 6'd1;
          if (step == 6'(SQ_W-1)) begin
            state <= S_SQRT;
            rr    <= '0;
            rbit  <= SQ_W'(1) << (SQ_W-2);
            step  <= '0;
          end
        end
        S_SQRT: begin
          if (step == 6'd0) begin
            rx   <= dq;
            step <= 6'd1;
          end else if (rbit != '0) begin
            if (rx >= rr + rbit) begin
              rx <= rx - (rr + rbit);
              rr <= (rr >> 1) + rbit;
            end else begin
              rr <= rr >> 1;
            end
            rbit <= rbit >> 2;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: if (load_sum) begin
          res.kind   <= tpwvs_pkg::RK_SUMMARY;
          res.phase  <= cur.job.phase;
          res.mask   <= '0;
          res.etime  <= '0;
          res.rms    <= rms_sat;
          res.p2p    <= cur.job.p2p;
          res.dc     <= dc_v;
          res.in_tol <= ({2'b0, rms_sat} > {2'b0, tolerance_low}) &&
                        ({2'b0, rms_sat} < {2'b0, tolerance_high});
          res.clips  <= cur.job.clips;
          res.last   <= cur.last;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/three_phase_window_voltage_stats.sv
// Three-phase window voltage statistics: top level, APB register file.
// Depends on tpwvs_pkg, tpwvs_front, tpwvs_fifo, tpwvs_back.
//
// Input queue: push a sample while full is low. Results: read while empty
// is low and pop to take one. Clip events and per-phase window summaries
// come out in order; is_last marks the final result of one sample.
// The front accumulates one sample per cycle while full is low into
// per-phase sums and queues up to four requests for that sample, one per
// cycle while q_full is low; full stays high until they are queued.
// The back end works one request at a time: a clip event is loaded straight
// into the output register, a summary goes through pop, 42 shared restoring
// divide steps, a square root and the output load. The 4-entry queue absorbs
// a closing window's requests while the front keeps going.
// A clip event passes the front's pending entry, the queue and the output register.
// Reset (synchronous, rst high) clears sums, counters, queue and
// restores the register defaults. When pop stays low, results wait in
// the output register and backpressure reaches full through the queue.
module three_phase_window_voltage_stats (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  logic signed [tpwvs_pkg::SAMPLE_BITS-1:0] phase_a_sample,
  input  logic signed [tpwvs_pkg::SAMPLE_BITS-1:0] phase_b_sample,
  input  logic signed [tpwvs_pkg::SAMPLE_BITS-1:0] phase_c_sample,
  input  logic [31:0]                   sample_time,
  output logic                          empty,
  input  logic                          pop,
  output logic                          result_kind,
  output logic [1:0]                    phase_index,
  output logic [2:0]                    clip_mask,
  output logic [31:0]                   event_time,
  output logic [14:0]                   rms_value,
  output logic [15:0]                   voltage_swing,
  output logic signed [15:0]            dc_offset,
  output logic                          in_tolerance,
  output logic [12:0]                   clip_total,
  output logic                          is_last
);
  logic [12:0] window_length;
  logic [14:0] tolerance_low, tolerance_high, clip_level;
  logic q_push, q_full, q_pop, q_empty;
  tpwvs_pkg::entry_t q_in, q_out;
  tpwvs_pkg::result_t res;

  // register file
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= tpwvs_pkg::WIN_RESET;
      tolerance_low  <= tpwvs_pkg::TLOW_RESET;
      tolerance_high <= tpwvs_pkg::THI_RESET;
      clip_level     <= tpwvs_pkg::CLIP_RESET;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      case (paddr[3:2])
        tpwvs_pkg::REG_WINDOW: window_length  <= pwdata[12:0];
        tpwvs_pkg::REG_TLOW:   tolerance_low  <= pwdata[14:0];
        tpwvs_pkg::REG_THI:    tolerance_high <= pwdata[14:0];
        tpwvs_pkg::REG_CLIP:   clip_level     <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tpwvs_pkg::REG_WINDOW: prdata = {19'd0, window_length};
      tpwvs_pkg::REG_TLOW:   prdata = {17'd0, tolerance_low};
      tpwvs_pkg::REG_THI:    prdata = {17'd0, tolerance_high};
      tpwvs_pkg::REG_CLIP:   prdata = {17'd0, clip_level};
      default:               prdata = '0;
    endcase
  end

  tpwvs_front u_front (
    .clk, .rst, .push, .full, .phase_a_sample, .phase_b_sample,
    .phase_c_sample, .sample_time, .window_length, .clip_level,
    .q_push, .q_data(q_in), .q_full
  );

  tpwvs_fifo u_fifo (
    .clk, .rst, .wr(q_push), .wdata(q_in), .q_full,
    .rd(q_pop), .rdata(q_out), .q_empty
  );

  tpwvs_back u_back (
    .clk, .rst, .q_data(q_out), .q_empty, .q_pop,
    .tolerance_low, .tolerance_high, .empty, .pop, .res
  );

  assign result_kind   = res.kind;
  assign phase_index   = res.phase;
  assign clip_mask     = res.mask;
  assign event_time    = res.etime;
  assign rms_value     = res.rms;
  assign voltage_swing = res.p2p;
  assign dc_offset     = res.dc;
  assign in_tolerance  = res.in_tol;
  assign clip_total    = res.clips;
  assign is_last       = res.last;
endmodule

FILE: sim/three_phase_window_voltage_stats_tb.sv
// Self-checking testbench for the three-phase window voltage statistics block.
// Depends on tpwvs_pkg and the RTL top level three_phase_window_voltage_stats.
// Directed table first, then randomized phases; results checked against an in-bench model.
module three_phase_window_voltage_stats_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 6000;
  localparam int DRAIN_WAIT  = 250;
  localparam int HOLD_CYCLES = 500;
  localparam int MAX_WIN     = 4096;
  localparam longint unsigned SQ_MAX = (64'd1 << 42) - 1;

  typedef enum logic { OP_SAMPLE, OP_WRITE } row_op_e;

  typedef struct {
    row_op_e            op;
    logic [1:0]         idx;
    int unsigned        val;
    logic signed [15:0] a, b, c;
    logic [31:0]        t;
    bit                 typed;
    logic [2:0]         mask;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic signed [15:0] phase_a_sample = '0, phase_b_sample = '0, phase_c_sample = '0;
  logic [31:0] sample_time = '0;
  logic empty;
  logic pop = 1'b0;
  logic result_kind;
  logic [1:0] phase_index;
  logic [2:0] clip_mask;
  logic [31:0] event_time;
  logic [14:0] rms_value;
  logic [15:0] voltage_swing;
  logic signed [15:0] dc_offset;
  logic in_tolerance;
  logic [12:0] clip_total;
  logic is_last;

  three_phase_window_voltage_stats DUT (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .phase_a_sample(phase_a_sample),
    .phase_b_sample(phase_b_sample), .phase_c_sample(phase_c_sample),
    .sample_time(sample_time), .empty(empty), .pop(pop),
    .result_kind(result_kind), .phase_index(phase_index), .clip_mask(clip_mask),
    .event_time(event_time), .rms_value(rms_value), .voltage_swing(voltage_swing),
    .dc_offset(dc_offset), .in_tolerance(in_tolerance), .clip_total(clip_total),
    .is_last(is_last)
  );

  always #6 clk = ~clk;

  // model copy of registers and window state
  int unsigned win_len_reg, tol_low_reg, tol_high_reg, clip_lvl_reg;
  longint unsigned sq_acc[3];
  longint sum_acc[3];
  int max_acc[3], min_acc[3];
  int clip_cnt[3];
  int samples_in_win;

  tpwvs_pkg::result_t pending_results[$];
  int mismatches = 0;
  bit no_idle = 1'b0;
  bit hold_request = 1'b0;
  int idle_cycles = 0;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic void clear_window_state();
    for (int p = 0; p < 3; p++) begin
      sq_acc[p] = 0; sum_acc[p] = 0; max_acc[p] = 0; min_acc[p] = 0; clip_cnt[p] = 0;
    end
    samples_in_win = 0;
  endfunction

  // accumulate one sample, return the clip event and summaries it causes
  function automatic void predict_window_stats(input logic signed [15:0] smp_in [3],
                                               input logic [31:0] stamp,
                                               ref tpwvs_pkg::result_t outq[$]);
    int smp;
    int n;
    logic [2:0] mask;
    longint unsigned sq, rms;
    longint dc;
    tpwvs_pkg::result_t r;
    mask = '0;
    for (int p = 0; p < 3; p++) begin
      smp = smp_in[p];
      sq = longint'(smp) * longint'(smp);
      sq_acc[p] = (SQ_MAX - sq_acc[p] < sq) ? SQ_MAX : sq_acc[p] + sq;
      sum_acc[p] += smp;
      if (smp > max_acc[p]) max_acc[p] = smp;
      else if (smp < min_acc[p]) min_acc[p] = smp;
      if (smp >= int'(clip_lvl_reg)) begin
        mask[p] = 1'b1;
        clip_cnt[p] = (clip_cnt[p] + 1) & 13'h1FFF;
      end
    end
    samples_in_win = (samples_in_win + 1) & 13'h1FFF;
    if (mask != 0) begin
      r = '0;
      r.kind = tpwvs_pkg::RK_CLIP;
      r.mask = mask;
      r.etime = stamp;
      outq.push_back(r);
    end
    n = (win_len_reg == 0) ? 1 : ((win_len_reg > MAX_WIN) ? MAX_WIN : win_len_reg);
    if (samples_in_win >= n) begin
      for (int p = 0; p < 3; p++) begin
        rms = floor_sqrt(sq_acc[p] / n);
        dc = sum_acc[p] / longint'(n);
        if (rms > 32767) rms = 32767;
        r = '0;
        r.kind = tpwvs_pkg::RK_SUMMARY;
        r.phase = p[1:0];
        r.rms = rms[14:0];
        r.p2p = 16'(max_acc[p] - min_acc[p]);
        r.dc = dc[15:0];
        r.in_tol = (rms > tol_low_reg && rms < tol_high_reg);
        r.clips = clip_cnt[p][12:0];
        outq.push_back(r);
      end
      clear_window_state();
    end
    if (outq.size() > 0) outq[outq.size()-1].last = 1'b1;
  endfunction

  // let the block go idle before touching registers
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // APB write followed by a read-back
  task automatic reg_write(input logic [1:0] idx, input int unsigned val);
    int unsigned keep;
    keep = (idx == tpwvs_pkg::REG_WINDOW) ? (val & 32'h1FFF) : (val & 32'h7FFF);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== keep) begin
      mismatches++;
      if (mismatches <= 10)
        $display("reg %0d readback: expected %0h got %0h", idx, keep, prdata);
    end
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    case (idx)
      tpwvs_pkg::REG_WINDOW: win_len_reg = keep;
      tpwvs_pkg::REG_TLOW:   tol_low_reg = keep;
      tpwvs_pkg::REG_THI:    tol_high_reg = keep;
      default:               clip_lvl_reg = keep;
    endcase
  endtask

  // offer one sample until taken, then queue what it should cause
  task automatic send_sample(input logic signed [15:0] a, b, c, input logic [31:0] t,
                             input bit typed, input logic [2:0] typed_mask);
    logic signed [15:0] smp [3];
    tpwvs_pkg::result_t got_q[$];
    tpwvs_pkg::result_t r;
    int gap;
    phase_a_sample <= a; phase_b_sample <= b; phase_c_sample <= c; sample_time <= t;
    push <= 1'b1;
    do @(posedge clk); while (full);
    smp[0] = a; smp[1] = b; smp[2] = c;
    predict_window_stats(smp, t, got_q);
    if (typed) begin
      if (typed_mask != 0) begin
        r = '0;
        r.kind = tpwvs_pkg::RK_CLIP; r.mask = typed_mask; r.etime = t; r.last = 1'b1;
        pending_results.push_back(r);
      end
    end else begin
      foreach (got_q[i]) pending_results.push_back(got_q[i]);
    end
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom);
    if (r < 70) return 16'(int'(clip_lvl_reg) + $urandom_range(0, 6) - 3);
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return 16'sh8000;
        1: return 16'sh7FFF;
        2: return 16'sh0000;
        default: return -16'sd1;
      endcase
    end
    return 16'($urandom_range(0, 400)) - 16'sd200;
  endfunction

  // receiver: check each accepted result, then choose the next pop
  initial begin
    tpwvs_pkg::result_t got, want;
    int gap;
    int hold_left;
    gap = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got = '{result_kind, phase_index, clip_mask, event_time, rms_value, voltage_swing,
                dc_offset, in_tolerance, clip_total, is_last};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with nothing expected: %p", got);
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.phase !== want.phase ||
              got.mask !== want.mask || got.etime !== want.etime ||
              got.rms !== want.rms || got.p2p !== want.p2p || got.dc !== want.dc ||
              got.in_tol !== want.in_tol || got.clips !== want.clips ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected %p", want);
              $display("          actual   %p", got);
            end
          end
        end
        gap = pick_gap();
      end
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else if (gap > 0) begin
        pop <= 1'b0;
        gap--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("three_phase_window_voltage_stats_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main stimulus
  initial begin
    row_t rows[$];
    row_t w;
    int hold_phase;
    win_len_reg = tpwvs_pkg::WIN_RESET; tol_low_reg = tpwvs_pkg::TLOW_RESET;
    tol_high_reg = tpwvs_pkg::THI_RESET; clip_lvl_reg = tpwvs_pkg::CLIP_RESET;
    clear_window_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; typed rows rely on reset defaults
    w = '{op: OP_SAMPLE, idx: 0, val: 0, a: 0, b: 0, c: 0, t: 0, typed: 1, mask: 0};
    rows.push_back(w);
    w.a = 16'sh7FFF; w.b = 16'sh7FFF; w.c = 16'sh7FFF; w.t = 32'hFFFF_FFFF; w.mask = 3'b111;
    rows.push_back(w);
    w.a = 16'sh8000; w.b = 16'sh8000; w.c = 16'sh8000; w.t = 1; w.mask = 3'b000;
    rows.push_back(w);
    // right at and just below the clip level
    w.a = 16'sd20794; w.b = 16'sd20793; w.c = 0; w.t = 2; w.mask = 3'b001;
    rows.push_back(w);
    w.a = 16'sd20793; w.b = 16'sd20794; w.c = 16'sd20794; w.t = 3; w.mask = 3'b110;
    rows.push_back(w);
    w.a = 0; w.b = 0; w.c = 16'sh7FFF; w.t = 32'h8000_0000; w.mask = 3'b100;
    rows.push_back(w);
    // shrinking the window mid-window closes it on the next sample
    w = '{op: OP_WRITE, idx: tpwvs_pkg::REG_WINDOW, val: 3, a: 0, b: 0, c: 0, t: 0,
          typed: 0, mask: 0};
    rows.push_back(w);
    w.idx = tpwvs_pkg::REG_TLOW; w.val = 0;     rows.push_back(w);
    w.idx = tpwvs_pkg::REG_THI;  w.val = 32767; rows.push_back(w);
    w.idx = tpwvs_pkg::REG_CLIP; w.val = 0;     rows.push_back(w);
    w = '{op: OP_SAMPLE, idx: 0, val: 0, a: 1, b: 2, c: 3, t: 10, typed: 0, mask: 0};
    rows.push_back(w);
    // full-scale negative window: RMS saturates
    w.a = 16'sh8000; w.b = 16'sh8000; w.c = 16'sh8000;
    for (int i = 0; i < 3; i++) begin w.t = 11 + i; rows.push_back(w); end
    // window length zero means one, inverted tolerance limits
    w = '{op: OP_WRITE, idx: tpwvs_pkg::REG_WINDOW, val: 0, a: 0, b: 0, c: 0, t: 0,
          typed: 0, mask: 0};
    rows.push_back(w);
    w.idx = tpwvs_pkg::REG_CLIP; w.val = 32767; rows.push_back(w);
    w.idx = tpwvs_pkg::REG_TLOW; w.val = 32767; rows.push_back(w);
    w.idx = tpwvs_pkg::REG_THI;  w.val = 0;     rows.push_back(w);
    w = '{op: OP_SAMPLE, idx: 0, val: 0, a: 16'sh7FFF, b: -16'sd1, c: 0, t: 20,
          typed: 0, mask: 0};
    rows.push_back(w);
    w.a = 100; w.b = -100; w.c = 5; w.t = 21; rows.push_back(w);
    // oversize window clamps to the maximum, then exact maximum, then close
    w = '{op: OP_WRITE, idx: tpwvs_pkg::REG_WINDOW, val: 8191, a: 0, b: 0, c: 0, t: 0,
          typed: 0, mask: 0};
    rows.push_back(w);
    w = '{op: OP_SAMPLE, idx: 0, val: 0, a: 500, b: -700, c: 16'sh7FFF, t: 30,
          typed: 0, mask: 0};
    rows.push_back(w);
    w.a = -500; w.b = 700; w.c = 16'sh8000; w.t = 31; rows.push_back(w);
    w = '{op: OP_WRITE, idx: tpwvs_pkg::REG_WINDOW, val: 4096, a: 0, b: 0, c: 0, t: 0,
          typed: 0, mask: 0};
    rows.push_back(w);
    w = '{op: OP_SAMPLE, idx: 0, val: 0, a: 7, b: 8, c: 9, t: 32, typed: 0, mask: 0};
    rows.push_back(w);
    w = '{op: OP_WRITE, idx: tpwvs_pkg::REG_WINDOW, val: 2, a: 0, b: 0, c: 0, t: 0,
          typed: 0, mask: 0};
    rows.push_back(w);
    w = '{op: OP_SAMPLE, idx: 0, val: 0, a: -7, b: -8, c: -9, t: 33, typed: 0, mask: 0};
    rows.push_back(w);

    foreach (rows[i]) begin
      if (rows[i].op == OP_WRITE) begin
        if (push) begin push <= 1'b0; @(posedge clk); end
        wait_drained();
        reg_write(rows[i].idx, rows[i].val);
      end else begin
        send_sample(rows[i].a, rows[i].b, rows[i].c, rows[i].t, rows[i].typed, rows[i].mask);
      end
    end

    // random phases with fresh settings
    hold_phase = $urandom_range(1, 6);
    for (int ph = 0; ph < 8; ph++) begin
      int r;
      push <= 1'b0;
      @(posedge clk);
      wait_drained();
      r = $urandom_range(0, 99);
      if (r < 60)      reg_write(tpwvs_pkg::REG_WINDOW, $urandom_range(1, 6));
      else if (r < 80) reg_write(tpwvs_pkg::REG_WINDOW, $urandom_range(7, 20));
      else if (r < 90) reg_write(tpwvs_pkg::REG_WINDOW, 0);
      else             reg_write(tpwvs_pkg::REG_WINDOW, $urandom_range(21, 60));
      reg_write(tpwvs_pkg::REG_TLOW, $urandom_range(0, 32767));
      reg_write(tpwvs_pkg::REG_THI, $urandom_range(0, 32767));
      reg_write(tpwvs_pkg::REG_CLIP, ($urandom_range(0, 1) != 0) ? $urandom_range(0, 32767)
                                                               : $urandom_range(19000, 22000));
      no_idle = (ph == 7);
      if (ph == hold_phase) hold_request = 1'b1;
      for (int i = 0; i < 35; i++)
        send_sample(rand_sample(), rand_sample(), rand_sample(), $urandom, 1'b0, 3'b000);
    end
    push <= 1'b0;

    // drain and finish
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("three_phase_window_voltage_stats_tb: PASS");
    end else begin
      $display("three_phase_window_voltage_stats_tb: FAIL");
    end
    $finish;
  end

endmodule
